### design/gcov_text_to_hit_bitmap_top_assert.svh
// assertion macros for the gcov hit bitmap top level
// expects clk_i and rst_ni in the scope of each use
`ifndef GCOV_TEXT_TO_HIT_BITMAP_TOP_ASSERT_SVH
`define GCOV_TEXT_TO_HIT_BITMAP_TOP_ASSERT_SVH

// same-cycle implication
`define GTHB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GTHB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/gthb_pkg.sv
// shared types, constants and helper functions for the gcov hit bitmap block
// no dependencies
package gthb_pkg;

  localparam int unsigned MAP_ENTRIES = 65536;
  localparam int unsigned IDX_W       = $clog2(MAP_ENTRIES + 1);
  localparam int unsigned ADDR_W      = $clog2(MAP_ENTRIES);

  localparam int unsigned OPQ_DEPTH = 4;
  localparam int unsigned OPQ_PTR_W = $clog2(OPQ_DEPTH);
  localparam int unsigned OPQ_CNT_W = $clog2(OPQ_DEPTH + 1);

  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  localparam int unsigned COUNT_SAT = 128;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [1:0] {
    CMD_TEXT = 2'd0,
    CMD_EOF  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    EV_COUNTED   = 2'd0,
    EV_UNCOVERED = 2'd1,
    EV_READ      = 2'd2
  } event_e;

  typedef enum logic [5:0] {
    PH_LEAD  = 6'b000001,
    PH_SIGN  = 6'b000010,
    PH_DIGIT = 6'b000100,
    PH_STAR  = 6'b001000,
    PH_BAD   = 6'b010000,
    PH_DONE  = 6'b100000
  } phase_e;

  typedef struct packed {
    event_e              ev;
    logic                in_range;
    logic [ADDR_W-1:0]   addr;
    logic [15:0]         index;
    logic [7:0]          value;
    logic                overflow;
  } op_t;

  typedef struct packed {
    event_e      ev;
    logic [15:0] index;
    logic [7:0]  value;
    logic        overflow;
  } res_t;

  typedef struct packed {
    logic             stopped;
    logic [IDX_W-1:0] next_index;
  } front_stat_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic [7:0] bucket_of(input logic [7:0] cnt, input logic neg);
    logic [7:0] b;
    priority if (neg || cnt == 8'd0) b = 8'h00;
    else if (cnt >= 8'd128) b = 8'h80;
    else if (cnt >= 8'd32)  b = 8'h40;
    else if (cnt >= 8'd16)  b = 8'h20;
    else if (cnt >= 8'd8)   b = 8'h10;
    else if (cnt >= 8'd4)   b = 8'h08;
    else if (cnt >= 8'd3)   b = 8'h04;
    else if (cnt >= 8'd2)   b = 8'h02;
    else                    b = 8'h01;
    return b;
  endfunction

endpackage

### design/gcov_text_to_hit_bitmap_top.sv
// latency: a result reaches the ports after its transaction passes the op queue, the bitmap stage and the result queue
// throughput: one transaction per cycle while full is low, set by the single bitmap memory port
// entries are written once each in index order, so nothing beyond the fill index
// is returned from memory: no clearing pass after reset, the block is ready at once
// reset: asynchronous, active low, clears parser state, fill index and queues
// depends on gthb_pkg, gthb_front, gthb_opq, gthb_back and the assertion header
`include "gcov_text_to_hit_bitmap_top_assert.svh"
module gcov_text_to_hit_bitmap_top import gthb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  text_byte_i,
  input  logic [15:0] read_index_i,
  input  logic        pop,
  output logic        empty,
  output logic [1:0]  event_res_o,
  output logic [15:0] entry_index_o,
  output logic [7:0]  entry_value_o,
  output logic        overflow_o
);

  logic        opq_wr;
  op_t         opq_wr_op;
  logic        opq_full;
  logic        opq_rd;
  op_t         opq_rd_op;
  logic        opq_empty;
  front_stat_t front_stat;
  res_t        res;

  gthb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .cmd_i       (cmd_i),
    .text_byte_i (text_byte_i),
    .read_index_i(read_index_i),
    .opq_full_i  (opq_full),
    .op_valid_o  (opq_wr),
    .op_o        (opq_wr_op),
    .stat_o      (front_stat)
  );

  gthb_opq u_opq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_en_i(opq_wr),
    .wr_op_i(opq_wr_op),
    .full_o (opq_full),
    .rd_en_i(opq_rd),
    .rd_op_o(opq_rd_op),
    .empty_o(opq_empty)
  );

  gthb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_empty_i (opq_empty),
    .op_i       (opq_rd_op),
    .op_pop_o   (opq_rd),
    .res_pop_i  (pop),
    .res_empty_o(empty),
    .res_o      (res)
  );

  assign full          = opq_full;
  assign event_res_o   = res.ev;
  assign entry_index_o = res.index;
  assign entry_value_o = res.value;
  assign overflow_o    = res.overflow;

  `GTHB_ASSERT_NEXT(a_stop_sticky, front_stat.stopped, front_stat.stopped, "stop flag cleared")
  `GTHB_ASSERT_IMP(a_index_bound, 1'b1, 32'(front_stat.next_index) <= 32'(MAP_ENTRIES), "index past map")
  `GTHB_ASSERT_IMP(a_no_push_full, opq_wr, !opq_full, "op queue written while full")
  `GTHB_ASSERT_IMP(a_ovf_stopped, !empty && overflow_o, front_stat.stopped, "overflow without stop")

endmodule

### design/gthb_front.sv
// front end: accepts transactions, parses line prefixes, owns the fill index
// depends on gthb_pkg
module gthb_front import gthb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  text_byte_i,
  input  logic [15:0] read_index_i,
  input  logic        opq_full_i,
  output logic        op_valid_o,
  output op_t         op_o,
  output front_stat_t stat_o
);

  phase_e           phase_q, phase_d;
  logic [7:0]       prev_q, prev_d;
  logic             hash_q, hash_d;
  logic [7:0]       count_q, count_d;
  logic             neg_q, neg_d;
  logic             stopped_q, stopped_d;
  logic [IDX_W-1:0] next_index_q, next_index_d;

  logic        accept;
  logic        clear_line;
  logic        is_digit;
  logic [3:0]  dval;
  logic [10:0] acc;
  logic [10:0] prod;
  logic [7:0]  count_sat;

  assign accept    = push && !opq_full_i;
  assign is_digit  = (text_byte_i >= CH_ZERO) && (text_byte_i <= CH_NINE);
  assign dval      = 4'(text_byte_i - CH_ZERO);
  assign acc       = {3'b000, count_q};
  assign prod      = (acc << 3) + (acc << 1) + {7'b0000000, dval};
  assign count_sat = (prod > 11'(COUNT_SAT)) ? 8'(COUNT_SAT) : prod[7:0];

  always_comb begin
    phase_d      = phase_q;
    prev_d       = prev_q;
    hash_d       = hash_q;
    count_d      = count_q;
    neg_d        = neg_q;
    stopped_d    = stopped_q;
    next_index_d = next_index_q;
    clear_line   = 1'b0;
    op_valid_o   = 1'b0;
    op_o         = '0;

    if (accept) begin
      unique case (cmd_e'(cmd_i))
        CMD_READ: begin
          op_valid_o     = 1'b1;
          op_o.ev        = EV_READ;
          op_o.addr      = ADDR_W'(read_index_i);
          op_o.index     = read_index_i;
          op_o.in_range  = 32'(read_index_i) < 32'(next_index_q);
          op_o.overflow  = stopped_q;
        end
        CMD_EOF: begin
          if (!stopped_q) clear_line = 1'b1;
        end
        CMD_TEXT: begin
          if (!stopped_q) begin
            if (text_byte_i == CH_LF) begin
              clear_line = 1'b1;
            end else if (phase_q != PH_DONE) begin
              if (text_byte_i == CH_COLON) begin
                phase_d = PH_DONE;
                if (prev_q != CH_MINUS &&
                    (hash_q || phase_q == PH_DIGIT || phase_q == PH_STAR)) begin
                  next_index_d  = next_index_q + 1'b1;
                  stopped_d     = (next_index_d == IDX_W'(MAP_ENTRIES));
                  op_valid_o    = 1'b1;
                  op_o.ev       = hash_q ? EV_UNCOVERED : EV_COUNTED;
                  op_o.addr     = ADDR_W'(next_index_q);
                  op_o.index    = 16'(next_index_q);
                  op_o.value    = hash_q ? 8'h00 : bucket_of(count_q, neg_q);
                  op_o.overflow = stopped_d;
                end
              end else begin
                if (text_byte_i == CH_HASH) hash_d = 1'b1;
                unique case (phase_q)
                  PH_LEAD: begin
                    if (is_ws(text_byte_i)) begin
                      phase_d = PH_LEAD;
                    end else if (text_byte_i == CH_PLUS || text_byte_i == CH_MINUS) begin
                      neg_d   = (text_byte_i == CH_MINUS);
                      phase_d = PH_SIGN;
                    end else if (is_digit) begin
                      count_d = 8'(dval);
                      phase_d = PH_DIGIT;
                    end else if (text_byte_i == CH_STAR) begin
                      phase_d = PH_STAR;
                    end else begin
                      phase_d = PH_BAD;
                    end
                  end
                  PH_SIGN, PH_DIGIT: begin
                    if (is_digit) begin
                      count_d = count_sat;
                      phase_d = PH_DIGIT;
                    end else if (text_byte_i == CH_STAR && phase_q == PH_DIGIT) begin
                      phase_d = PH_STAR;
                    end else begin
                      phase_d = PH_BAD;
                    end
                  end
                  default: phase_d = PH_BAD;
                endcase
                prev_d = text_byte_i;
              end
            end
          end
        end
        CMD_NOP: begin
          clear_line = 1'b0;
        end
      endcase
    end

    if (clear_line) begin
      phase_d = PH_LEAD;
      prev_d  = 8'h00;
      hash_d  = 1'b0;
      count_d = 8'h00;
      neg_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_LEAD;
      prev_q       <= 8'h00;
      hash_q       <= 1'b0;
      count_q      <= 8'h00;
      neg_q        <= 1'b0;
      stopped_q    <= 1'b0;
      next_index_q <= '0;
    end else begin
      phase_q      <= phase_d;
      prev_q       <= prev_d;
      hash_q       <= hash_d;
      count_q      <= count_d;
      neg_q        <= neg_d;
      stopped_q    <= stopped_d;
      next_index_q <= next_index_d;
    end
  end

  assign stat_o = '{stopped: stopped_q, next_index: next_index_q};

endmodule

### design/gthb_opq.sv
// short operation queue between the parsing front end and the bitmap back end
// depends on gthb_pkg
module gthb_opq import gthb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  op_t  wr_op_i,
  output logic full_o,
  input  logic rd_en_i,
  output op_t  rd_op_o,
  output logic empty_o
);

  op_t                  slots_q [OPQ_DEPTH];
  logic [OPQ_PTR_W-1:0] wptr_q, rptr_q;
  logic [OPQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                 do_wr, do_rd;

  assign full_o  = (cnt_q == OPQ_CNT_W'(OPQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_en_i && !full_o;
  assign do_rd   = rd_en_i && !empty_o;
  assign rd_op_o = slots_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_wr && !do_rd) cnt_d = cnt_q + 1'b1;
    if (do_rd && !do_wr) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) slots_q[wptr_q] <= wr_op_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) wptr_q <= wptr_q + 1'b1;
      if (do_rd) rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

endmodule

### design/gthb_back.sv
// back end: bitmap memory write or read per operation, result queue
// depends on gthb_pkg
module gthb_back import gthb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic op_empty_i,
  input  op_t  op_i,
  output logic op_pop_o,
  input  logic res_pop_i,
  output logic res_empty_o,
  output res_t res_o
);

  logic [7:0]           mem [MAP_ENTRIES];
  logic [7:0]           rd_q;
  op_t                  s1_op_q;
  logic                 s1_v_q;
  res_t                 res_slots_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wptr_q, rptr_q;
  logic [RES_CNT_W-1:0] cnt_q, cnt_d;
  logic                 issue, do_pop;
  res_t                 res_new;

  assign issue    = !op_empty_i &&
                    (({1'b0, cnt_q} + RES_CNT_W'(s1_v_q)) < (RES_CNT_W + 1)'(RES_DEPTH));
  assign op_pop_o = issue;

  always_ff @(posedge clk_i) begin
    if (issue) begin
      if (op_i.ev != EV_READ) mem[op_i.addr] <= op_i.value;
      rd_q    <= mem[op_i.addr];
      s1_op_q <= op_i;
    end
  end

  always_comb begin
    res_new.ev       = s1_op_q.ev;
    res_new.index    = s1_op_q.index;
    res_new.overflow = s1_op_q.overflow;
    if (s1_op_q.ev == EV_READ) begin
      res_new.value = s1_op_q.in_range ? rd_q : 8'h00;
    end else begin
      res_new.value = s1_op_q.value;
    end
  end

  assign res_empty_o = (cnt_q == '0);
  assign do_pop      = res_pop_i && !res_empty_o;
  assign res_o       = res_slots_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (s1_v_q && !do_pop) cnt_d = cnt_q + 1'b1;
    if (do_pop && !s1_v_q) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q) res_slots_q[wptr_q] <= res_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      s1_v_q <= issue;
      if (s1_v_q) wptr_q <= wptr_q + 1'b1;
      if (do_pop) rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for gcov_text_to_hit_bitmap_top: gcov text, end of file and
// bitmap reads go in through the push side, events are checked against a line-parser model
// depends on gthb_pkg and the design sources
module tb import gthb_pkg::*; ();

  typedef logic [7:0] byte_q_t[$];

  class gcov_bitmap_tracker;
    logic [7:0]  hit_map [MAP_ENTRIES];
    int unsigned fill_index;
    phase_e      phase;
    logic [7:0]  last_char;
    bit          hash_seen;
    int unsigned count;
    bit          minus;
    bit          halted;
    res_t        pending_events[$];
    int unsigned errors;

    function new();
      foreach (hit_map[i]) hit_map[i] = 8'h00;
      fill_index = 0;
      halted     = 1'b0;
      errors     = 0;
      start_line();
    endfunction

    function void start_line();
      phase     = PH_LEAD;
      last_char = 8'h00;
      hash_seen = 1'b0;
      count     = 0;
      minus     = 1'b0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function logic [7:0] bucket_bit(int unsigned n, bit neg);
      int unsigned lower[8] = '{1, 2, 3, 4, 8, 16, 32, 128};
      if (neg || n == 0) return 8'h00;
      for (int k = 7; k >= 0; k--) begin
        if (n >= lower[k]) return 8'h01 << k;
      end
      return 8'h00;
    endfunction

    function void queue_event(event_e ev, int unsigned idx, logic [7:0] val);
      res_t r;
      r.ev       = ev;
      r.index    = idx[15:0];
      r.value    = val;
      r.overflow = halted;
      pending_events.push_back(r);
    endfunction

    function void bump_index();
      fill_index++;
      if (fill_index >= MAP_ENTRIES) halted = 1'b1;
    endfunction

    function void at_colon();
      int unsigned idx;
      bit          ok;
      bit          dash;
      idx   = fill_index;
      ok    = (phase == PH_DIGIT) || (phase == PH_STAR);
      dash  = (last_char == CH_MINUS);
      phase = PH_DONE;
      if (dash) return;
      if (hash_seen) begin
        bump_index();
        queue_event(EV_UNCOVERED, idx, 8'h00);
        return;
      end
      if (!ok || idx >= MAP_ENTRIES) return;
      hit_map[idx] = hit_map[idx] | bucket_bit(count, minus);
      bump_index();
      queue_event(EV_COUNTED, idx, hit_map[idx]);
    endfunction

    function void prefix_byte(logic [7:0] c);
      if (c == CH_HASH) hash_seen = 1'b1;
      case (phase)
        PH_LEAD: begin
          if (!is_blank(c)) begin
            if (c == CH_PLUS || c == CH_MINUS) begin
              minus = (c == CH_MINUS);
              phase = PH_SIGN;
            end else if (is_digit(c)) begin
              count = c - CH_ZERO;
              phase = PH_DIGIT;
            end else if (c == CH_STAR) begin
              phase = PH_STAR;
            end else begin
              phase = PH_BAD;
            end
          end
        end
        PH_SIGN, PH_DIGIT: begin
          if (is_digit(c)) begin
            count = count * 10 + (c - CH_ZERO);
            if (count > COUNT_SAT) count = COUNT_SAT;
            phase = PH_DIGIT;
          end else if (c == CH_STAR && phase == PH_DIGIT) begin
            phase = PH_STAR;
          end else begin
            phase = PH_BAD;
          end
        end
        default: phase = PH_BAD;
      endcase
      last_char = c;
    endfunction

    function void note_item(cmd_e cmd, logic [7:0] c, logic [15:0] ridx);
      if (cmd == CMD_READ) begin
        queue_event(EV_READ, ridx, (ridx < MAP_ENTRIES) ? hit_map[ridx] : 8'h00);
        return;
      end
      if (cmd == CMD_NOP || halted) return;
      if (cmd == CMD_EOF || c == CH_LF) begin
        start_line();
        return;
      end
      if (phase == PH_DONE) return;
      if (c == CH_COLON) at_colon();
      else prefix_byte(c);
    endfunction

    function void mismatch(string field, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    function void check_event(res_t got);
      res_t want;
      if (pending_events.size() == 0) begin
        errors++;
        $display("%0t: event with nothing expected, actual ev %0d index %0h value %0h",
                 $time, got.ev, got.index, got.value);
        return;
      end
      want = pending_events.pop_front();
      if (got.ev !== want.ev) mismatch("event_res", want.ev, got.ev);
      if (got.index !== want.index) mismatch("entry_index", want.index, got.index);
      if (got.value !== want.value) mismatch("entry_value", want.value, got.value);
      if (got.overflow !== want.overflow) mismatch("overflow", want.overflow, got.overflow);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  cmd_i = CMD_NOP;
  logic [7:0]  text_byte_i = 8'h00;
  logic [15:0] read_index_i = 16'h0000;
  logic        pop = 1'b0;
  logic        empty;
  logic [1:0]  event_res_o;
  logic [15:0] entry_index_o;
  logic [7:0]  entry_value_o;
  logic        overflow_o;

  gcov_bitmap_tracker tracker = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned pop_hold_cycles = 0;
  int unsigned items_sent = 0;

  gcov_text_to_hit_bitmap_top dut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  // result side: random stalls plus an optional long hold-off
  initial begin
    res_t got;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (pop_hold_cycles > 0) begin
        pop <= 1'b0;
        pop_hold_cycles--;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
      @(posedge clk_i);
      if (pop && !empty) begin
        got.ev       = event_e'(event_res_o);
        got.index    = entry_index_o;
        got.value    = entry_value_o;
        got.overflow = overflow_o;
        tracker.check_event(got);
      end
    end
  end

  task automatic send_item(cmd_e cmd, logic [7:0] c, logic [15:0] ridx);
    logic [7:0]  byte_val;
    logic [15:0] idx_val;
    byte_val = (cmd == CMD_TEXT) ? c : 8'($urandom);
    idx_val  = (cmd == CMD_READ) ? ridx : 16'($urandom);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push         <= 1'b1;
    cmd_i        <= cmd;
    text_byte_i  <= byte_val;
    read_index_i <= idx_val;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    tracker.note_item(cmd, byte_val, idx_val);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++) send_item(CMD_TEXT, s[i], 16'h0000);
  endtask

  task automatic send_read();
    logic [15:0] idx;
    case ($urandom_range(0, 3))
      0: idx = (tracker.fill_index > 0) ? 16'($urandom_range(0, tracker.fill_index - 1)) : 16'h0;
      1: idx = 16'($urandom);
      2: idx = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: idx = 16'(tracker.fill_index - $urandom_range(0, 3));
    endcase
    send_item(CMD_READ, 8'h00, idx);
  endtask

  function automatic logic [7:0] rand_blank();
    int unsigned k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CH_SPACE : 8'(CH_TAB + k);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  task automatic send_random_line();
    byte_q_t     line;
    int unsigned kind;
    int unsigned r;
    kind = $urandom_range(0, 19);
    repeat ($urandom_range(0, 2)) line.push_back(rand_blank());
    if (kind <= 8) begin
      if ($urandom_range(0, 4) == 0) line.push_back($urandom_range(0, 3) ? CH_PLUS : CH_MINUS);
      repeat (($urandom_range(0, 5) == 0) ? $urandom_range(3, 5) : $urandom_range(1, 2))
        line.push_back(rand_digit());
      if ($urandom_range(0, 3) == 0) line.push_back(CH_STAR);
    end else if (kind == 9) begin
      line.push_back(CH_STAR);
    end else if (kind <= 13) begin
      if ($urandom_range(0, 3) == 0) line.push_back(rand_digit());
      repeat ($urandom_range(1, 5)) line.push_back(CH_HASH);
    end else if (kind <= 15) begin
      if ($urandom_range(0, 1)) line.push_back(rand_digit());
      line.push_back(CH_MINUS);
    end else if (kind <= 17) begin
      repeat ($urandom_range(0, 5)) line.push_back(8'($urandom));
    end else begin
      line.push_back(rand_digit());
      case ($urandom_range(0, 3))
        0: line.push_back(rand_blank());
        1: line.push_back(CH_PLUS);
        2: line.push_back(CH_STAR);
        default: line.push_back(8'($urandom));
      endcase
      if ($urandom_range(0, 1)) line.push_back(rand_digit());
    end
    if ($urandom_range(0, 9) != 0) line.push_back(CH_COLON);
    repeat ($urandom_range(0, 3)) line.push_back(8'($urandom));
    foreach (line[i]) send_item(CMD_TEXT, line[i], 16'h0000);
    r = $urandom_range(0, 19);
    if (r < 17) send_item(CMD_TEXT, CH_LF, 16'h0000);
    else if (r < 19) send_item(CMD_EOF, 8'h00, 16'h0000);
  endtask

  task automatic run_phase(int unsigned idle, int unsigned stall, int unsigned n);
    int unsigned target;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    target         = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(0, 9) == 0) send_read();
      if ($urandom_range(0, 29) == 0) send_item(CMD_NOP, 8'h00, 16'h0000);
      send_random_line();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed lines
    send_str(":\n");
    send_str("7:");
    send_item(CMD_TEXT, 8'hFF, 16'h0000);
    send_str("\n#:");
    send_item(CMD_EOF, 8'h00, 16'h0000);
    send_str("-:\n999*:\n\t-5:\n");
    send_item(CMD_TEXT, 8'h00, 16'h0000);
    send_str(":\n*:");
    send_item(CMD_READ, 8'h00, 16'h0000);
    send_item(CMD_READ, 8'h00, 16'hFFFF);
    send_item(CMD_NOP, 8'h00, 16'h0000);
    send_item(CMD_EOF, 8'h00, 16'h0000);

    run_phase(0, 0, 130);
    run_phase(45, 0, 130);
    run_phase(0, 45, 130);
    run_phase(38, 38, 130);

    // long receiver hold-off so the block backs up into full
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    pop_hold_cycles = 150;
    repeat (40) send_read();
    run_phase(0, 0, 80);

    repeat (5) send_random_line();
    send_item(CMD_EOF, 8'h00, 16'h0000);
    send_item(CMD_READ, 8'h00, 16'hFFFF);
    repeat (10) send_read();
    push <= 1'b0;

    while (tracker.pending_events.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending_events.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### gcov_text_to_hit_bitmap_top.f
+incdir+design
design/gthb_pkg.sv
design/gthb_front.sv
design/gthb_opq.sv
design/gthb_back.sv
design/gcov_text_to_hit_bitmap_top.sv
test/tb.sv
